[hdl/vsc_pkg.sv]
// Package for the video sync pulse classifier: register map, reset values,
// pulse class codes and the structs passed between the modules.
// No dependencies.
package vsc_pkg;

  // Default widths for the timer and the line counter
  localparam int TIME_WIDTH_DEF = 16;
  localparam int LINE_WIDTH_DEF = 10;

  // Configuration register file
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VSYNC_MIN        = 3'd0,
    CFG_VSYNC_MAX        = 3'd1,
    CFG_SHORT_SYNC_MAX   = 3'd2,
    CFG_HSYNC_MAX        = 3'd3,
    CFG_LINE_START_DELAY = 3'd4,
    CFG_ADC_SAMPLE_DELAY = 3'd5,
    CFG_DMA_SKEW         = 3'd6
  } cfg_idx_t;

  localparam logic [REG_W-1:0] VSYNC_MIN_RST        = 16'd1200;
  localparam logic [REG_W-1:0] VSYNC_MAX_RST        = 16'd1680;
  localparam logic [REG_W-1:0] SHORT_SYNC_MAX_RST   = 16'd192;
  localparam logic [REG_W-1:0] HSYNC_MAX_RST        = 16'd384;
  localparam logic [REG_W-1:0] LINE_START_DELAY_RST = 16'd288;
  localparam logic [REG_W-1:0] ADC_SAMPLE_DELAY_RST = 16'd912;
  localparam logic [REG_W-1:0] DMA_SKEW_RST         = 16'd32;

  // Line counter reload values on a short sync
  localparam int LINE_RELOAD_SECOND = 15;
  localparam int LINE_RELOAD_FIRST  = 14;

  typedef enum logic [1:0] {
    CLS_SHORT = 2'd0,
    CLS_HSYNC = 2'd1,
    CLS_BROAD = 2'd2,
    CLS_GAP   = 2'd3
  } pulse_class_t;

  typedef struct packed {
    logic [REG_W-1:0] vsync_min;
    logic [REG_W-1:0] vsync_max;
    logic [REG_W-1:0] short_sync_max;
    logic [REG_W-1:0] hsync_max;
    logic [REG_W-1:0] line_start_delay;
    logic [REG_W-1:0] adc_sample_delay;
    logic [REG_W-1:0] dma_skew;
  } vsc_cfg_t;

  typedef struct packed {
    pulse_class_t pulse_class;
    logic         second_field;
    logic         render_page;
    logic         line_start_valid;
  } vsc_status_t;

endpackage

[hdl/vsc_regs.sv]
// Configuration register file of the sync classifier.
// Depends on vsc_pkg (register map, reset values, vsc_cfg_t).
module vsc_regs
  import vsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output vsc_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vsync_min        <= VSYNC_MIN_RST;
      cfg.vsync_max        <= VSYNC_MAX_RST;
      cfg.short_sync_max   <= SHORT_SYNC_MAX_RST;
      cfg.hsync_max        <= HSYNC_MAX_RST;
      cfg.line_start_delay <= LINE_START_DELAY_RST;
      cfg.adc_sample_delay <= ADC_SAMPLE_DELAY_RST;
      cfg.dma_skew         <= DMA_SKEW_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_VSYNC_MIN:        cfg.vsync_min        <= wr_data;
        CFG_VSYNC_MAX:        cfg.vsync_max        <= wr_data;
        CFG_SHORT_SYNC_MAX:   cfg.short_sync_max   <= wr_data;
        CFG_HSYNC_MAX:        cfg.hsync_max        <= wr_data;
        CFG_LINE_START_DELAY: cfg.line_start_delay <= wr_data;
        CFG_ADC_SAMPLE_DELAY: cfg.adc_sample_delay <= wr_data;
        CFG_DMA_SKEW:         cfg.dma_skew         <= wr_data;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

[hdl/vsc_core.sv]
// Edge classifier core: pulse measurement, classification and the sync state
// (last edge time, field flag, line counter, render page).
// Depends on vsc_pkg (vsc_cfg_t, vsc_status_t, class codes).
module vsc_core
  import vsc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [TIME_WIDTH-1:0] edge_time,
  input  logic                  edge_rising,
  input  vsc_cfg_t              cfg,
  output logic [TIME_WIDTH-1:0] pulse_length,
  output vsc_status_t           status,
  output logic [LINE_WIDTH-1:0] line_number,
  output logic [TIME_WIDTH-1:0] line_start_time,
  output logic [TIME_WIDTH-1:0] dma_late_time,
  output logic [TIME_WIDTH-1:0] adc_sample_time
);

  localparam int CW = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;

  logic [TIME_WIDTH-1:0] last_edge_time, last_edge_time_next;
  logic                  field_flag, field_flag_next;
  logic [LINE_WIDTH-1:0] line_counter, line_counter_next;
  logic                  page_select, page_select_next;

  logic [CW-1:0]         len_ext;
  logic                  in_vsync_gap;
  logic                  is_short;
  logic                  is_hsync;
  logic [TIME_WIDTH-1:0] start_sum;
  pulse_class_t          cls;

  assign pulse_length = edge_time - last_edge_time;
  assign len_ext      = CW'(pulse_length);
  assign in_vsync_gap = (len_ext > CW'(cfg.vsync_min)) && (len_ext < CW'(cfg.vsync_max));
  assign is_short     = len_ext < CW'(cfg.short_sync_max);
  assign is_hsync     = !is_short && (len_ext < CW'(cfg.hsync_max));
  assign start_sum    = edge_time + TIME_WIDTH'(cfg.line_start_delay);

  always_comb begin
    last_edge_time_next = edge_time;
    field_flag_next     = field_flag;
    line_counter_next   = line_counter;
    page_select_next    = page_select;
    line_start_time     = '0;
    dma_late_time       = '0;
    adc_sample_time     = '0;
    if (!edge_rising) begin
      cls = CLS_GAP;
      if (in_vsync_gap) begin
        field_flag_next = 1'b1;
      end
    end else if (is_short) begin
      cls = CLS_SHORT;
      line_counter_next = field_flag ? LINE_WIDTH'(LINE_RELOAD_SECOND)
                                     : LINE_WIDTH'(LINE_RELOAD_FIRST);
    end else if (is_hsync) begin
      cls = CLS_HSYNC;
      line_start_time     = start_sum;
      dma_late_time       = start_sum + TIME_WIDTH'(cfg.dma_skew);
      adc_sample_time     = start_sum + TIME_WIDTH'(cfg.adc_sample_delay);
      last_edge_time_next = start_sum;
      page_select_next    = !page_select;
      line_counter_next   = line_counter + LINE_WIDTH'(2);
      field_flag_next     = 1'b0;
    end else begin
      cls = CLS_BROAD;
    end
  end

  assign status.pulse_class      = cls;
  assign status.second_field     = field_flag_next;
  assign status.render_page      = page_select_next;
  assign status.line_start_valid = is_hsync && edge_rising;
  assign line_number             = line_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      field_flag     <= 1'b0;
      line_counter   <= '0;
      page_select    <= 1'b0;
    end else if (fire) begin
      last_edge_time <= last_edge_time_next;
      field_flag     <= field_flag_next;
      line_counter   <= line_counter_next;
      page_select    <= page_select_next;
    end
  end

endmodule

[hdl/video_sync_pulse_classifier_unit.sv]
// Composite video sync separator: classifies comparator edges into short,
// horizontal and broad syncs and gaps, and schedules line trigger times.
// An accepted edge passes the input register, then the result register; one
// edge is accepted per cycle while the result is not stalled. A stalled
// result with a full input register stalls the input until the result is
// taken.
// Reset (rst, synchronous, active high) empties both stages, clears the sync
// state and loads the default timing registers. Depends on vsc_pkg.
module video_sync_pulse_classifier_unit
  import vsc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // edge requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_WIDTH-1:0] edge_time,
  input  logic                  edge_rising,
  // result requests
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_WIDTH-1:0] pulse_length,
  output logic [1:0]            pulse_class,
  output logic                  second_field,
  output logic [LINE_WIDTH-1:0] line_number,
  output logic                  render_page,
  output logic                  line_start_valid,
  output logic [TIME_WIDTH-1:0] line_start_time,
  output logic [TIME_WIDTH-1:0] dma_late_time,
  output logic [TIME_WIDTH-1:0] adc_sample_time,
  // configuration write requests
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  vsc_cfg_t cfg;

  // Input stage: captured edge waiting for the classifier
  logic                  s1_valid;
  logic [TIME_WIDTH-1:0] s1_time;
  logic                  s1_rising;

  logic                  s1_go;
  logic                  accept_in;
  logic                  fire;

  vsc_status_t           c_status;
  logic [TIME_WIDTH-1:0] c_length;
  logic [LINE_WIDTH-1:0] c_line;
  logic [TIME_WIDTH-1:0] c_start;
  logic [TIME_WIDTH-1:0] c_late;
  logic [TIME_WIDTH-1:0] c_adc;

  // Registers are always writable; the user must change the configuration only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  vsc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The input stage advances whenever the result register is empty or being
  // taken; with a stalled result and a full input stage, stall the input.
  assign s1_go     = !out_valid || !out_stall;
  assign fire      = s1_valid && s1_go;
  assign in_stall  = s1_valid && !s1_go;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_time   <= edge_time;
      s1_rising <= edge_rising;
    end
  end

  // Classify and update the sync state in the cycle the edge leaves stage 1
  vsc_core #(
    .TIME_WIDTH (TIME_WIDTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .edge_time       (s1_time),
    .edge_rising     (s1_rising),
    .cfg             (cfg),
    .pulse_length    (c_length),
    .status          (c_status),
    .line_number     (c_line),
    .line_start_time (c_start),
    .dma_late_time   (c_late),
    .adc_sample_time (c_adc)
  );

  // Result register: hold while stalled, load on every classified edge
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pulse_length     <= c_length;
      pulse_class      <= c_status.pulse_class;
      second_field     <= c_status.second_field;
      line_number      <= c_line;
      render_page      <= c_status.render_page;
      line_start_valid <= c_status.line_start_valid;
      line_start_time  <= c_start;
      dma_late_time    <= c_late;
      adc_sample_time  <= c_adc;
    end
  end

endmodule

[hdl/vsc_checker.sv]
// Port-level checker for the sync classifier, bound to the top level.
// Depends on vsc_pkg (class codes, reload values).
module vsc_checker
  import vsc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [TIME_WIDTH-1:0] pulse_length,
  input logic [1:0]            pulse_class,
  input logic                  second_field,
  input logic [LINE_WIDTH-1:0] line_number,
  input logic                  line_start_valid,
  input logic [TIME_WIDTH-1:0] line_start_time,
  input logic [TIME_WIDTH-1:0] dma_late_time,
  input logic [TIME_WIDTH-1:0] adc_sample_time
);

  // Trigger times only travel with an hsync
  a_trigger_only_hsync: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_start_valid == (pulse_class == CLS_HSYNC)))
    else $error("line_start_valid does not match hsync class");

  a_idle_times_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !line_start_valid) |->
      (line_start_time == '0 && dma_late_time == '0 && adc_sample_time == '0))
    else $error("trigger times nonzero without hsync");

  // An hsync returns to the first field; a short sync reloads by field
  a_hsync_first_field: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pulse_class == CLS_HSYNC) |-> !second_field)
    else $error("hsync left second field flagged");

  a_short_reload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pulse_class == CLS_SHORT) |->
      (line_number == (second_field ? LINE_WIDTH'(LINE_RELOAD_SECOND)
                                    : LINE_WIDTH'(LINE_RELOAD_FIRST))))
    else $error("short sync line reload wrong");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pulse_length)))
    else $error("stalled result changed");

endmodule

bind video_sync_pulse_classifier_unit vsc_checker #(
  .TIME_WIDTH (TIME_WIDTH),
  .LINE_WIDTH (LINE_WIDTH)
) u_vsc_checker (.*);
